// File: design/ckbb_pkg.sv
`default_nettype none

package ckbb_pkg;

    localparam int COORD_LIMIT = 1024;
    localparam int COORD_W     = $clog2(COORD_LIMIT);
    localparam int PIX_W       = 8;
    localparam int GAIN_W      = 12;
    localparam int SPILL_W     = 10;
    localparam int CFG_W       = 12;
    localparam int CFG_IDX_W   = 3;

    // key_gain * (g - r), then scaled by 1/255 through a reciprocal
    localparam int PROD_W  = GAIN_W + PIX_W;
    localparam int RECIP_S = 28;
    localparam int RECIP_W = 21;
    localparam logic [RECIP_W-1:0] RECIP_255 = RECIP_W'(((1 << RECIP_S) + 254) / 255);
    localparam int SCALED_W = PROD_W + RECIP_W;
    localparam int DROP_W   = 12;

    localparam int ALPHA_W = PIX_W + 1;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(256);
    localparam int LIM_W   = SPILL_W;
    localparam int MIX_W   = ALPHA_W + PIX_W;

    localparam logic [PIX_W-1:0] PIX_MAX = '1;

    localparam logic [COORD_W-1:0] TOP_ROW_RST     = COORD_W'(25);
    localparam logic [COORD_W-1:0] BOTTOM_ROW_RST  = COORD_W'(460);
    localparam logic [COORD_W-1:0] LEFT_COL_RST    = COORD_W'(80);
    localparam logic [COORD_W-1:0] RIGHT_COL_RST   = COORD_W'(575);
    localparam logic [GAIN_W-1:0]  KEY_GAIN_RST    = GAIN_W'(1920);
    localparam logic [SPILL_W-1:0] SPILL_RATIO_RST = SPILL_W'(333);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_ENABLE  = 3'd0,
        CFG_TOP_ROW     = 3'd1,
        CFG_BOTTOM_ROW  = 3'd2,
        CFG_LEFT_COL    = 3'd3,
        CFG_RIGHT_COL   = 3'd4,
        CFG_KEY_GAIN    = 3'd5,
        CFG_SPILL_RATIO = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        t_rgb             fg;
        t_rgb             bg;
        logic [PIX_W-1:0] diff;
        logic             pos;
        logic             byp;
    } t_s1;

    typedef struct packed {
        t_rgb              fg;
        t_rgb              bg;
        logic [PROD_W-1:0] prod;
        logic [LIM_W-1:0]  lim;
        logic              pos;
        logic              byp;
    } t_s2;

    typedef struct packed {
        t_rgb              fg;
        t_rgb              bg;
        logic [DROP_W-1:0] drop;
        logic [PIX_W-1:0]  glim;
        logic              pos;
        logic              byp;
    } t_s3;

    typedef struct packed {
        t_rgb               fg;
        t_rgb               bg;
        logic [ALPHA_W-1:0] alpha;
    } t_s4;

endpackage

`default_nettype wire

// File: design/chroma_key_background_blend_core.sv
`default_nettype none
// channel | valid   | stall   | payload
// --------+---------+---------+-------------------------------------------
// pixel in| i_valid | o_stall | i_row i_col i_fg_* i_bg_*
// blend   | o_valid | i_stall | o_out_red o_out_green o_out_blue
// config  | i_cfg_we| -       | i_cfg_index i_cfg_data
//
// One pixel per cycle while the output is not stalled; each pixel passes through
// the registered stages mask, two multiply stages, alpha/spill and the blend multiplier stage.
// Reset (synchronous, low) empties the pipeline and restores the border,
// gain and spill defaults; keying comes up disabled.
// A stall on the output holds each full stage with no empty stage after it; empty stages keep filling.
module chroma_key_background_blend_core (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_valid,
    output logic                        o_stall,
    input  wire  [ckbb_pkg::COORD_W-1:0] i_row,
    input  wire  [ckbb_pkg::COORD_W-1:0] i_col,
    input  wire  [ckbb_pkg::PIX_W-1:0]   i_fg_red,
    input  wire  [ckbb_pkg::PIX_W-1:0]   i_fg_green,
    input  wire  [ckbb_pkg::PIX_W-1:0]   i_fg_blue,
    input  wire  [ckbb_pkg::PIX_W-1:0]   i_bg_red,
    input  wire  [ckbb_pkg::PIX_W-1:0]   i_bg_green,
    input  wire  [ckbb_pkg::PIX_W-1:0]   i_bg_blue,
    output logic                        o_valid,
    input  wire                         i_stall,
    output logic [ckbb_pkg::PIX_W-1:0]   o_out_red,
    output logic [ckbb_pkg::PIX_W-1:0]   o_out_green,
    output logic [ckbb_pkg::PIX_W-1:0]   o_out_blue,
    input  wire                         i_cfg_we,
    input  wire  [ckbb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [ckbb_pkg::CFG_W-1:0]   i_cfg_data
);
    import ckbb_pkg::*;

    // configuration
    logic               r_key_enable;
    logic [COORD_W-1:0] r_top_row;
    logic [COORD_W-1:0] r_bottom_row;
    logic [COORD_W-1:0] r_left_col;
    logic [COORD_W-1:0] r_right_col;
    logic [GAIN_W-1:0]  r_key_gain;
    logic [SPILL_W-1:0] r_spill_ratio;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_enable  <= 1'b0;
            r_top_row     <= TOP_ROW_RST;
            r_bottom_row  <= BOTTOM_ROW_RST;
            r_left_col    <= LEFT_COL_RST;
            r_right_col   <= RIGHT_COL_RST;
            r_key_gain    <= KEY_GAIN_RST;
            r_spill_ratio <= SPILL_RATIO_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KEY_ENABLE:  r_key_enable  <= i_cfg_data[0];
                CFG_TOP_ROW:     r_top_row     <= i_cfg_data[COORD_W-1:0];
                CFG_BOTTOM_ROW:  r_bottom_row  <= i_cfg_data[COORD_W-1:0];
                CFG_LEFT_COL:    r_left_col    <= i_cfg_data[COORD_W-1:0];
                CFG_RIGHT_COL:   r_right_col   <= i_cfg_data[COORD_W-1:0];
                CFG_KEY_GAIN:    r_key_gain    <= i_cfg_data[GAIN_W-1:0];
                CFG_SPILL_RATIO: r_spill_ratio <= i_cfg_data[SPILL_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline handshake: a stage takes a beat when empty or when it drains
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5;

    assign w_rdy5  = !r_v5 || !i_stall;
    assign w_rdy4  = !r_v4 || w_rdy5;
    assign w_rdy3  = !r_v3 || w_rdy4;
    assign w_rdy2  = !r_v2 || w_rdy3;
    assign w_rdy1  = !r_v1 || w_rdy2;
    assign o_stall = !w_rdy1;

    // stage 1: border mask
    t_s1  n_s1, r_s1;
    logic w_outside;

    always_comb begin
        w_outside = (i_row > r_bottom_row) || (i_row < r_top_row) ||
                    (i_col > r_right_col) || (i_col < r_left_col);
        n_s1.fg.red   = i_fg_red;
        n_s1.fg.green = i_fg_green;
        n_s1.fg.blue  = i_fg_blue;
        if (r_key_enable && w_outside) begin
            n_s1.fg.red   = '0;
            n_s1.fg.green = PIX_MAX;
            n_s1.fg.blue  = '0;
        end
        n_s1.bg.red   = i_bg_red;
        n_s1.bg.green = i_bg_green;
        n_s1.bg.blue  = i_bg_blue;
        n_s1.diff     = n_s1.fg.green - n_s1.fg.red;
        n_s1.pos      = n_s1.fg.green > n_s1.fg.red;
        n_s1.byp      = !r_key_enable;
    end

    // stage 2: gain and spill products
    t_s2 n_s2, r_s2;

    always_comb begin
        n_s2.fg   = r_s1.fg;
        n_s2.bg   = r_s1.bg;
        n_s2.prod = PROD_W'(r_s1.diff) * PROD_W'(r_key_gain);
        n_s2.lim  = LIM_W'((LIM_W + PIX_W)'(r_spill_ratio) *
                           (LIM_W + PIX_W)'(r_s1.fg.red) >> PIX_W);
        n_s2.pos  = r_s1.pos;
        n_s2.byp  = r_s1.byp;
    end

    // stage 3: divide by 255 through the reciprocal, limit green
    t_s3                 n_s3, r_s3;
    logic [SCALED_W-1:0] w_scaled;

    always_comb begin
        w_scaled  = SCALED_W'(r_s2.prod) * SCALED_W'(RECIP_255);
        n_s3.fg   = r_s2.fg;
        n_s3.bg   = r_s2.bg;
        n_s3.drop = w_scaled[RECIP_S +: DROP_W];
        if (LIM_W'(r_s2.fg.green) > r_s2.lim) begin
            n_s3.glim = PIX_W'(r_s2.lim);
        end else begin
            n_s3.glim = r_s2.fg.green;
        end
        n_s3.pos  = r_s2.pos;
        n_s3.byp  = r_s2.byp;
    end

    // stage 4: alpha; bypass blends at full alpha with green untouched
    t_s4 n_s4, r_s4;

    always_comb begin
        n_s4.fg = r_s3.fg;
        n_s4.bg = r_s3.bg;
        if (r_s3.byp || !r_s3.pos) begin
            n_s4.alpha = ALPHA_ONE;
        end else if (r_s3.drop >= DROP_W'(ALPHA_ONE)) begin
            n_s4.alpha = '0;
        end else begin
            n_s4.alpha = ALPHA_ONE - ALPHA_W'(r_s3.drop);
        end
        if (!r_s3.byp) begin
            n_s4.fg.green = r_s3.glim;
        end
    end

    // stage 5: blend
    logic [ALPHA_W-1:0] w_beta;
    logic [MIX_W-1:0]   w_mix_r, w_mix_g, w_mix_b;
    logic [PIX_W-1:0]   n_out_red, n_out_green, n_out_blue;
    logic [PIX_W-1:0]   r_out_red, r_out_green, r_out_blue;

    always_comb begin
        w_beta  = ALPHA_ONE - r_s4.alpha;
        w_mix_r = MIX_W'(r_s4.alpha) * MIX_W'(r_s4.fg.red) +
                  MIX_W'(w_beta) * MIX_W'(r_s4.bg.red);
        w_mix_g = MIX_W'(r_s4.alpha) * MIX_W'(r_s4.fg.green) +
                  MIX_W'(w_beta) * MIX_W'(r_s4.bg.green);
        w_mix_b = MIX_W'(r_s4.alpha) * MIX_W'(r_s4.fg.blue) +
                  MIX_W'(w_beta) * MIX_W'(r_s4.bg.blue);
        n_out_red   = w_mix_r[PIX_W +: PIX_W];
        n_out_green = w_mix_g[PIX_W +: PIX_W];
        n_out_blue  = w_mix_b[PIX_W +: PIX_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
            if (w_rdy5) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) r_s1 <= n_s1;
        if (w_rdy2) r_s2 <= n_s2;
        if (w_rdy3) r_s3 <= n_s3;
        if (w_rdy4) r_s4 <= n_s4;
        if (w_rdy5) begin
            r_out_red   <= n_out_red;
            r_out_green <= n_out_green;
            r_out_blue  <= n_out_blue;
        end
    end

    assign o_valid     = r_v5;
    assign o_out_red   = r_out_red;
    assign o_out_green = r_out_green;
    assign o_out_blue  = r_out_blue;

endmodule

`default_nettype wire

// File: design/ckbb_chk.sv
`default_nettype none

module ckbb_chk (
    input wire                         i_clk,
    input wire                         i_rst_n,
    input wire                         o_stall,
    input wire                         o_valid,
    input wire                         i_stall,
    input wire [ckbb_pkg::PIX_W-1:0]   o_out_red,
    input wire [ckbb_pkg::PIX_W-1:0]   o_out_green,
    input wire [ckbb_pkg::PIX_W-1:0]   o_out_blue
);
    import ckbb_pkg::*;

    // reset empties the pipeline
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // a draining output never backs up into the input
    a_drain_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while output drains");

    // no held result means every stage can advance
    a_empty_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> !o_stall)
        else $error("input stalled with no result waiting");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_red) &&
            $stable(o_out_green) && $stable(o_out_blue))
        else $error("stalled result changed");

endmodule

bind chroma_key_background_blend_core ckbb_chk u_ckbb_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_out_red   (o_out_red),
    .o_out_green (o_out_green),
    .o_out_blue  (o_out_blue)
);

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import ckbb_pkg::*;

    localparam int PIPE_LAT    = 5;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;
    localparam int RGB_W       = 3 * PIX_W;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(7);
    localparam logic [CFG_W-1:0] ENABLE_MASK = CFG_W'(1);
    localparam logic [CFG_W-1:0] COORD_MASK  = CFG_W'((1 << COORD_W) - 1);
    localparam logic [CFG_W-1:0] GAIN_MASK   = CFG_W'((1 << GAIN_W) - 1);
    localparam logic [CFG_W-1:0] SPILL_MASK  = CFG_W'((1 << SPILL_W) - 1);

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        t_rgb               fg;
        t_rgb               bg;
    } t_pixel;

    typedef struct packed {
        logic               key_enable;
        logic [COORD_W-1:0] top_row;
        logic [COORD_W-1:0] bottom_row;
        logic [COORD_W-1:0] left_col;
        logic [COORD_W-1:0] right_col;
        logic [GAIN_W-1:0]  key_gain;
        logic [SPILL_W-1:0] spill_ratio;
    } t_key_settings;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_stall;
    logic [COORD_W-1:0]   i_row       = '0;
    logic [COORD_W-1:0]   i_col       = '0;
    logic [PIX_W-1:0]     i_fg_red    = '0;
    logic [PIX_W-1:0]     i_fg_green  = '0;
    logic [PIX_W-1:0]     i_fg_blue   = '0;
    logic [PIX_W-1:0]     i_bg_red    = '0;
    logic [PIX_W-1:0]     i_bg_green  = '0;
    logic [PIX_W-1:0]     i_bg_blue   = '0;
    logic                 o_valid;
    logic                 i_stall     = 1'b0;
    logic [PIX_W-1:0]     o_out_red;
    logic [PIX_W-1:0]     o_out_green;
    logic [PIX_W-1:0]     o_out_blue;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_KEY_ENABLE;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    t_key_settings keyer_cfg = '{1'b0, TOP_ROW_RST, BOTTOM_ROW_RST, LEFT_COL_RST,
                                 RIGHT_COL_RST, KEY_GAIN_RST, SPILL_RATIO_RST};
    t_rgb          blend_queue[$];
    int            fail_count     = 0;
    int            pixels_sent    = 0;
    int            settings_count = 0;
    int            masked_count   = 0;
    int            partial_count  = 0;
    int            gap_pct        = 0;
    int            stall_pct      = 0;
    bit            calm           = 1'b0;
    int unsigned   cycle_count    = 0;

    chroma_key_background_blend_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_row       (i_row),
        .i_col       (i_col),
        .i_fg_red    (i_fg_red),
        .i_fg_green  (i_fg_green),
        .i_fg_blue   (i_fg_blue),
        .i_bg_red    (i_bg_red),
        .i_bg_green  (i_bg_green),
        .i_bg_blue   (i_bg_blue),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_red   (o_out_red),
        .o_out_green (o_out_green),
        .o_out_blue  (o_out_blue),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d blends outstanding",
                     cycle_count, blend_queue.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int unsigned mix_channel(int unsigned alpha, int unsigned f,
                                                int unsigned b);
        return ((alpha * f + (256 - alpha) * b) >> 8) & 8'hFF;
    endfunction

    function automatic t_rgb blend_pixel(t_pixel p);
        int unsigned r, g, b, alpha, drop, lim, glim;
        t_rgb        res;
        r = p.fg.red;
        g = p.fg.green;
        b = p.fg.blue;
        if (!keyer_cfg.key_enable)
            return p.fg;
        // outside the border rectangle the pixel becomes pure green screen
        if (p.row > keyer_cfg.bottom_row || p.row < keyer_cfg.top_row ||
            p.col > keyer_cfg.right_col || p.col < keyer_cfg.left_col) begin
            r = 0;
            g = PIX_MAX;
            b = 0;
            masked_count++;
        end
        if (g <= r) begin
            alpha = 256;
        end else begin
            drop  = keyer_cfg.key_gain * (g - r) / 255;
            alpha = (drop >= 256) ? 0 : 256 - drop;
        end
        if (alpha != 0 && alpha != 256)
            partial_count++;
        // alpha keys on the unlimited green
        lim  = (keyer_cfg.spill_ratio * r) >> 8;
        glim = (g > lim) ? lim : g;
        res.red   = PIX_W'(mix_channel(alpha, r, p.bg.red));
        res.green = PIX_W'(mix_channel(alpha, glim, p.bg.green));
        res.blue  = PIX_W'(mix_channel(alpha, b, p.bg.blue));
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_rgb got;
        t_rgb want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = '{o_out_red, o_out_green, o_out_blue};
            if (blend_queue.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: unexpected blend r=%0d g=%0d b=%0d",
                             $realtime, got.red, got.green, got.blue);
            end else begin
                want = blend_queue.pop_front();
                if (got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: blend mismatch exp r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                                 $realtime, want.red, want.green, want.blue,
                                 got.red, got.green, got.blue);
                end
            end
        end
    end

    // output backpressure in random bursts
    initial begin
        int left;
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 99) < stall_pct) begin
                i_stall <= 1'b1;
                left = $urandom_range(1, 19);
                while (left > 0 && !calm) begin
                    @(posedge i_clk);
                    left--;
                end
                i_stall <= 1'b0;
            end
        end
    end

    task automatic send_pixel(t_pixel p);
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_row      <= p.row;
        i_col      <= p.col;
        i_fg_red   <= p.fg.red;
        i_fg_green <= p.fg.green;
        i_fg_blue  <= p.fg.blue;
        i_bg_red   <= p.bg.red;
        i_bg_green <= p.bg.green;
        i_bg_blue  <= p.bg.blue;
        do @(posedge i_clk); while (o_stall);
        blend_queue.insert(blend_queue.size(), blend_pixel(p));
        pixels_sent++;
    endtask

    task automatic drain_pipeline();
        i_valid <= 1'b0;
        while (blend_queue.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 2) @(posedge i_clk);
    endtask

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value,
                           logic [CFG_W-1:0] field_mask);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        // random bits above the field width must be dropped by the block
        i_cfg_data  <= (CFG_W'($urandom) & ~field_mask) | (value & field_mask);
        @(posedge i_clk);
    endtask

    task automatic load_settings(t_key_settings s);
        put_reg(CFG_KEY_ENABLE, CFG_W'(s.key_enable), ENABLE_MASK);
        put_reg(CFG_TOP_ROW, CFG_W'(s.top_row), COORD_MASK);
        put_reg(CFG_BOTTOM_ROW, CFG_W'(s.bottom_row), COORD_MASK);
        put_reg(CFG_LEFT_COL, CFG_W'(s.left_col), COORD_MASK);
        put_reg(CFG_RIGHT_COL, CFG_W'(s.right_col), COORD_MASK);
        put_reg(CFG_KEY_GAIN, CFG_W'(s.key_gain), GAIN_MASK);
        put_reg(CFG_SPILL_RATIO, CFG_W'(s.spill_ratio), SPILL_MASK);
        put_reg(CFG_UNUSED, '0, '0);
        i_cfg_we <= 1'b0;
        keyer_cfg = s;
        settings_count++;
    endtask

    function automatic t_pixel px(int row, int col, int fr, int fgn, int fb,
                                  int br, int bgn, int bb);
        t_pixel p;
        p.row = COORD_W'(row);
        p.col = COORD_W'(col);
        p.fg  = '{PIX_W'(fr), PIX_W'(fgn), PIX_W'(fb)};
        p.bg  = '{PIX_W'(br), PIX_W'(bgn), PIX_W'(bb)};
        return p;
    endfunction

    function automatic t_key_settings random_settings();
        t_key_settings s;
        s.key_enable = ($urandom_range(0, 5) != 0);
        case ($urandom_range(0, 3))
            0: begin
                s.top_row    = '0;
                s.bottom_row = '1;
                s.left_col   = '0;
                s.right_col  = '1;
            end
            1: begin
                // may come out empty or inverted
                s.top_row    = COORD_W'($urandom);
                s.bottom_row = COORD_W'($urandom);
                s.left_col   = COORD_W'($urandom);
                s.right_col  = COORD_W'($urandom);
            end
            default: begin
                s.top_row    = COORD_W'($urandom_range(0, 400));
                s.bottom_row = COORD_W'($urandom_range(s.top_row, 1023));
                s.left_col   = COORD_W'($urandom_range(0, 400));
                s.right_col  = COORD_W'($urandom_range(s.left_col, 1023));
            end
        endcase
        if ($urandom_range(0, 4) == 0)
            s.key_gain = $urandom_range(0, 1) ? '1 : '0;
        else
            s.key_gain = GAIN_W'($urandom);
        if ($urandom_range(0, 4) == 0)
            s.spill_ratio = $urandom_range(0, 1) ? '1 : '0;
        else
            s.spill_ratio = SPILL_W'($urandom);
        return s;
    endfunction

    function automatic t_pixel random_pixel(t_key_settings s);
        t_pixel p;
        p.row = COORD_W'($urandom);
        p.col = COORD_W'($urandom);
        p.fg  = t_rgb'(RGB_W'($urandom));
        p.bg  = t_rgb'(RGB_W'($urandom));
        // hug the border edges often
        case ($urandom_range(0, 3))
            0: p.row = COORD_W'(s.top_row + $urandom_range(0, 4) - 2);
            1: p.row = COORD_W'(s.bottom_row + $urandom_range(0, 4) - 2);
            default: ;
        endcase
        case ($urandom_range(0, 3))
            0: p.col = COORD_W'(s.left_col + $urandom_range(0, 4) - 2);
            1: p.col = COORD_W'(s.right_col + $urandom_range(0, 4) - 2);
            default: ;
        endcase
        case ($urandom_range(0, 4))
            0: begin
                p.fg.green = PIX_W'($urandom_range(100, 255));
                p.fg.red   = PIX_W'($urandom_range(0, p.fg.green));
            end
            1: begin
                // slight green excess gives partial alpha
                p.fg.green = PIX_W'($urandom_range(60, 255));
                p.fg.red   = PIX_W'(p.fg.green - $urandom_range(0, 40));
            end
            default: ;
        endcase
        return p;
    endfunction

    task automatic test_passthrough_after_reset();
        send_pixel(px(0, 0, 0, 0, 0, 255, 255, 255));
        send_pixel(px(1023, 1023, 255, 255, 255, 0, 0, 0));
        send_pixel(px(341, 682, 85, 170, 90, 170, 85, 165));
        drain_pipeline();
    endtask

    task automatic test_border_and_key_edges();
        t_key_settings s;
        s = keyer_cfg;
        s.key_enable = 1'b1;
        load_settings(s);
        send_pixel(px(100, 100, 200, 50, 30, 10, 20, 30));
        send_pixel(px(100, 100, 128, 128, 128, 250, 5, 60));
        send_pixel(px(100, 100, 100, 110, 50, 200, 200, 200));
        send_pixel(px(100, 100, 0, 255, 0, 77, 144, 211));
        send_pixel(px(100, 100, 100, 200, 100, 30, 60, 90));
        send_pixel(px(100, 100, 255, 255, 255, 255, 255, 255));
        send_pixel(px(25, 300, 180, 90, 40, 1, 2, 3));
        send_pixel(px(24, 300, 180, 90, 40, 1, 2, 3));
        send_pixel(px(460, 300, 180, 90, 40, 1, 2, 3));
        send_pixel(px(461, 300, 180, 90, 40, 1, 2, 3));
        send_pixel(px(200, 80, 180, 90, 40, 1, 2, 3));
        send_pixel(px(200, 79, 180, 90, 40, 1, 2, 3));
        send_pixel(px(200, 575, 180, 90, 40, 1, 2, 3));
        send_pixel(px(200, 576, 180, 90, 40, 1, 2, 3));
        send_pixel(px(0, 0, 255, 0, 255, 255, 255, 255));
        send_pixel(px(1023, 1023, 255, 0, 255, 0, 0, 0));
        drain_pipeline();
    endtask

    task automatic test_degenerate_settings();
        t_key_settings s;
        // inverted rectangle masks everything; gain and spill at max
        s = '{1'b1, COORD_W'(600), COORD_W'(100), COORD_W'(700), COORD_W'(50), '1, '1};
        load_settings(s);
        send_pixel(px(300, 300, 10, 200, 10, 90, 100, 110));
        send_pixel(px(700, 700, 255, 255, 255, 255, 0, 255));
        drain_pipeline();
        // full-frame rectangle, no keying slope, green limited to zero
        s = '{1'b1, '0, '1, '0, '1, '0, '0};
        load_settings(s);
        send_pixel(px(0, 0, 20, 240, 60, 100, 100, 100));
        send_pixel(px(1023, 1023, 255, 255, 255, 0, 0, 0));
        drain_pipeline();
    endtask

    task automatic test_random_phases();
        t_key_settings s;
        int            n;
        for (int ph = 0; ph < 5; ph++) begin
            s = random_settings();
            if (ph == 4) begin
                calm = 1'b1;
            end else begin
                gap_pct   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
                stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
            end
            load_settings(s);
            n = $urandom_range(90, 110);
            for (int k = 0; k < n; k++) begin
                // hold off until every blend is back, then resume
                if (ph == 1 && k == n / 2)
                    drain_pipeline();
                send_pixel(random_pixel(s));
            end
            drain_pipeline();
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_passthrough_after_reset();
        test_border_and_key_edges();
        test_degenerate_settings();
        test_random_phases();
        drain_pipeline();
        $display("Blended %0d pixels under %0d register settings;", pixels_sent,
                 settings_count);
        $display("%0d pixels fell outside the border, %0d got a partial alpha.",
                 masked_count, partial_count);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
